>>> rtl/core/crsp_pkg.sv
package crsp_pkg;

  // Field widths
  localparam int CoordW  = 32;   // signed Q16.16 coordinate
  localparam int TW      = 17;   // unsigned Q1.16 curve parameter, 1.0 included
  localparam int FracW   = 16;   // local parameter and its powers, Q0.16
  localparam int CntW    = 5;    // point count register
  localparam int SlotW   = 4;    // load slot field
  localparam int NumAxes = 3;
  localparam int NumTaps = 4;    // control points per segment

  // Scaled parameter: integer part is the segment, low FracW bits the fraction
  localparam int ScaledW = TW + CntW;
  localparam int SegW    = ScaledW - FracW;

  // Cubic coefficient and product widths (exact, no overflow possible)
  localparam int E3W = CoordW + 3;   // -p0 + 3p1 - 3p2 + p3
  localparam int E2W = CoordW + 4;   // 2p0 - 5p1 + 4p2 - p3
  localparam int E1W = CoordW + 1;   // p2 - p0
  localparam int M3W = E3W + FracW + 1;
  localparam int M2W = E2W + FracW + 1;
  localparam int M1W = E1W + FracW + 1;
  localparam int AccW = 56;
  localparam int OutShift = FracW + 1;        // times 0.5, back to Q16.16
  localparam int QW = AccW - OutShift;

  localparam logic [CntW-1:0] PointCountReset = CntW'(6);
  localparam logic [CntW-1:0] MinPoints       = CntW'(4);

  localparam logic [2*FracW-1:0]   RoundQ16 = (2*FracW)'(32768);
  localparam logic signed [AccW-1:0] AccRound = AccW'(65536);

  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [NumAxes-1:0] point_t;

endpackage

>>> rtl/core/catmull_rom_spline_point.sv
// Uniform Catmull-Rom point evaluator, 3D, Q16.16. Load items (action 0)
// write one control point into a 16-slot table; evaluate items (action 1)
// map t in Q1.16 onto the point_count-1 curve segments and return x, y, z
// saturated to 32 bits. The block is a six-stage pipeline that takes one item
// in every cycle: busy_o is never raised and cfg_ready_o is always high.
// Each evaluate gives one result on pos_*_o, marked by done_o for exactly one
// cycle; loads give none. Each result passes the chain of table read,
// coefficient build, two multiply levels and the final add and saturate,
// each behind its own register. The table is kept in four identical copies
// so that the four neighbor points of a segment are read in parallel. Results
// leave in the order the evaluates came in and cannot be held off. The table
// is not cleared at reset: evaluate only after loading every point that
// point_count puts in use. Write point_count only while no evaluate is in
// flight.
module catmull_rom_spline_point #(
  parameter int MaxPoints = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          action_i,
  input  logic [crsp_pkg::SlotW-1:0]    point_index_i,
  input  logic signed [crsp_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [crsp_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [crsp_pkg::CoordW-1:0] coord_z_i,
  input  logic [crsp_pkg::TW-1:0]       t_value_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [crsp_pkg::CntW-1:0]     cfg_data_i,
  output logic                          done_o,
  output logic signed [crsp_pkg::CoordW-1:0] pos_x_o,
  output logic signed [crsp_pkg::CoordW-1:0] pos_y_o,
  output logic signed [crsp_pkg::CoordW-1:0] pos_z_o
);
  import crsp_pkg::*;

  localparam int IdxW = $clog2(MaxPoints);

  // Handshake: the pipeline never stalls
  logic accept;
  logic load_en;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign load_en     = accept && !action_i && (int'(point_index_i) < MaxPoints);

  // Point count register
  logic [CntW-1:0] pc_q;

  // Stage valids
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PointCountReset;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        pc_q <= cfg_data_i;
      end
      s1_v_q  <= accept && action_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      out_v_q <= s5_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: scale t by the segment count, pick the four neighbor slots
  // ---------------------------------------------------------------------
  logic [TW-1:0]      s1_t_q;
  logic [CntW-1:0]    n_eff;
  logic [CntW-1:0]    segs;
  logic [ScaledW-1:0] scaled;
  logic [SegW-1:0]    n_ext, last, seg_raw, seg;
  logic [SegW-1:0]    i0, i2, i3;
  logic [FracW-1:0]   s1_f;
  logic [IdxW-1:0]    rd_addr [NumTaps];

  always_comb begin
    // Clamp the point count to MinPoints..MaxPoints
    if (pc_q < MinPoints) begin
      n_eff = MinPoints;
    end else if (int'(pc_q) > MaxPoints) begin
      n_eff = CntW'(MaxPoints);
    end else begin
      n_eff = pc_q;
    end
    segs    = n_eff - CntW'(1);
    scaled  = ScaledW'(s1_t_q) * ScaledW'(segs);
    s1_f    = scaled[FracW-1:0];
    seg_raw = scaled[ScaledW-1:FracW];
    n_ext   = SegW'(n_eff);
    last    = n_ext - SegW'(1);
    // Cap the segment at the last point; the fraction stays as is
    seg     = (seg_raw > last) ? last : seg_raw;

    i0 = (seg == '0) ? '0 : seg - SegW'(1);
    i2 = seg + SegW'(1);
    i3 = seg + SegW'(2);
    if (i2 >= n_ext) begin
      i2 = seg;
      i3 = seg;
    end
    if (i3 >= n_ext) begin
      i3 = i2;
    end

    rd_addr[0] = IdxW'(i0);
    rd_addr[1] = IdxW'(seg);
    rd_addr[2] = IdxW'(i2);
    rd_addr[3] = IdxW'(i3);
  end

  // ---------------------------------------------------------------------
  // Point table: four copies, one read port each, registered read data
  // ---------------------------------------------------------------------
  point_t wr_pt;
  point_t s2_pt_q [NumTaps];

  always_comb begin
    wr_pt        = '0;
    wr_pt[AxisX] = coord_x_i;
    wr_pt[AxisY] = coord_y_i;
    wr_pt[AxisZ] = coord_z_i;
  end

  for (genvar b = 0; b < NumTaps; b++) begin : g_bank
    point_t mem [MaxPoints];

    always_ff @(posedge clk_i) begin
      if (load_en) begin
        mem[IdxW'(point_index_i)] <= wr_pt;
      end
      s2_pt_q[b] <= mem[rd_addr[b]];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: f^2 and the cubic coefficients per axis
  // ---------------------------------------------------------------------
  logic [FracW-1:0]   s2_f_q;
  logic [2*FracW-1:0] f2_full;
  logic [FracW-1:0]   f2_d;
  logic signed [CoordW-1:0] p0 [NumAxes];
  logic signed [CoordW-1:0] p1 [NumAxes];
  logic signed [CoordW-1:0] p2 [NumAxes];
  logic signed [CoordW-1:0] p3 [NumAxes];
  logic signed [E3W-1:0] e3_d [NumAxes];
  logic signed [E2W-1:0] e2_d [NumAxes];
  logic signed [E1W-1:0] e1_d [NumAxes];

  always_comb begin
    f2_full = (2*FracW)'(s2_f_q) * (2*FracW)'(s2_f_q) + RoundQ16;
    f2_d    = f2_full[2*FracW-1:FracW];
    for (int k = 0; k < NumAxes; k++) begin
      p0[k] = signed'(s2_pt_q[0][k]);
      p1[k] = signed'(s2_pt_q[1][k]);
      p2[k] = signed'(s2_pt_q[2][k]);
      p3[k] = signed'(s2_pt_q[3][k]);
      e3_d[k] = -E3W'(p0[k]) + 3 * E3W'(p1[k]) - 3 * E3W'(p2[k]) + E3W'(p3[k]);
      e2_d[k] = 2 * E2W'(p0[k]) - 5 * E2W'(p1[k]) + 4 * E2W'(p2[k]) - E2W'(p3[k]);
      e1_d[k] = E1W'(p2[k]) - E1W'(p0[k]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: f^3, e2*f^2 and e1*f
  // ---------------------------------------------------------------------
  logic [FracW-1:0]   s3_f_q, s3_f2_q;
  logic signed [E3W-1:0]    s3_e3_q [NumAxes];
  logic signed [E2W-1:0]    s3_e2_q [NumAxes];
  logic signed [E1W-1:0]    s3_e1_q [NumAxes];
  logic signed [CoordW-1:0] s3_p1_q [NumAxes];
  logic [2*FracW-1:0]       f3_full;
  logic [FracW-1:0]         f3_d;
  logic signed [FracW:0]    s3_f_s, s3_f2_s;
  logic signed [M2W-1:0]    m2_d [NumAxes];
  logic signed [M1W-1:0]    m1_d [NumAxes];

  always_comb begin
    f3_full = (2*FracW)'(s3_f2_q) * (2*FracW)'(s3_f_q) + RoundQ16;
    f3_d    = f3_full[2*FracW-1:FracW];
    s3_f_s  = signed'({1'b0, s3_f_q});
    s3_f2_s = signed'({1'b0, s3_f2_q});
    for (int k = 0; k < NumAxes; k++) begin
      m2_d[k] = s3_e2_q[k] * s3_f2_s;
      m1_d[k] = s3_e1_q[k] * s3_f_s;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: e3*f^3 and the sum of the other terms
  // ---------------------------------------------------------------------
  logic [FracW-1:0]         s4_f3_q;
  logic signed [E3W-1:0]    s4_e3_q [NumAxes];
  logic signed [M2W-1:0]    s4_m2_q [NumAxes];
  logic signed [M1W-1:0]    s4_m1_q [NumAxes];
  logic signed [CoordW-1:0] s4_p1_q [NumAxes];
  logic signed [FracW:0]    s4_f3_s;
  logic signed [M3W-1:0]    m3_d [NumAxes];
  logic signed [AccW-1:0]   part_d [NumAxes];

  always_comb begin
    s4_f3_s = signed'({1'b0, s4_f3_q});
    for (int k = 0; k < NumAxes; k++) begin
      m3_d[k]   = s4_e3_q[k] * s4_f3_s;
      // 2*p1 in Q16.16 times 2^16, plus the rounding half of the final shift
      part_d[k] = AccW'(s4_m2_q[k]) + AccW'(s4_m1_q[k])
                + (AccW'(s4_p1_q[k]) <<< OutShift) + AccRound;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: final add, halve with floor, saturate to 32 bits
  // ---------------------------------------------------------------------
  logic signed [M3W-1:0]    s5_m3_q   [NumAxes];
  logic signed [AccW-1:0]   s5_part_q [NumAxes];
  logic signed [AccW-1:0]   acc       [NumAxes];
  logic signed [QW-1:0]     q         [NumAxes];
  logic signed [CoordW-1:0] sat_d     [NumAxes];
  logic signed [CoordW-1:0] pos_q     [NumAxes];

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      acc[k] = AccW'(s5_m3_q[k]) + s5_part_q[k];
      q[k]   = acc[k][AccW-1:OutShift];
      if (!q[k][QW-1] && (|q[k][QW-2:CoordW-1])) begin
        sat_d[k] = {1'b0, {(CoordW-1){1'b1}}};
      end else if (q[k][QW-1] && !(&q[k][QW-2:CoordW-1])) begin
        sat_d[k] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        sat_d[k] = q[k][CoordW-1:0];
      end
    end
  end

  // Payload pipeline: advance every cycle, no reset needed
  always_ff @(posedge clk_i) begin
    s1_t_q  <= t_value_i;
    s2_f_q  <= s1_f;
    s3_f_q  <= s2_f_q;
    s3_f2_q <= f2_d;
    s4_f3_q <= f3_d;
    for (int k = 0; k < NumAxes; k++) begin
      s3_e3_q[k]   <= e3_d[k];
      s3_e2_q[k]   <= e2_d[k];
      s3_e1_q[k]   <= e1_d[k];
      s3_p1_q[k]   <= p1[k];
      s4_e3_q[k]   <= s3_e3_q[k];
      s4_m2_q[k]   <= m2_d[k];
      s4_m1_q[k]   <= m1_d[k];
      s4_p1_q[k]   <= s3_p1_q[k];
      s5_m3_q[k]   <= m3_d[k];
      s5_part_q[k] <= part_d[k];
      pos_q[k]     <= sat_d[k];
    end
  end

  assign done_o  = out_v_q;
  assign pos_x_o = pos_q[AxisX];
  assign pos_y_o = pos_q[AxisY];
  assign pos_z_o = pos_q[AxisZ];

endmodule

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crsp_pkg::*;

  localparam int MaxPoints = 16;
  // Pipeline depth of the block, in stages.
  localparam int PipeDepth = 6;
  localparam int CycleLimit = 200000;
  localparam int PrintCap = 40;

  // Action codes of an input item.
  localparam logic ActLoad = 1'b0;
  localparam logic ActEval = 1'b1;

  localparam longint CoordMax = 2147483647;
  localparam longint CoordMin = -CoordMax - 1;
  localparam longint FracOne = longint'(1) << FracW;
  localparam longint FracHalf = longint'(1) << (FracW - 1);
  localparam logic [TW-1:0] TOne = TW'(65536);
  localparam logic [TW-1:0] TTop = '1;

  typedef struct {
    point_t pos;
    logic [TW-1:0] t;
    int serial;
  } expected_pos_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic action_i;
  logic [SlotW-1:0] point_index_i;
  coord_t coord_x_i;
  coord_t coord_y_i;
  coord_t coord_z_i;
  logic [TW-1:0] t_value_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CntW-1:0] cfg_data_i;
  logic done_o;
  coord_t pos_x_o;
  coord_t pos_y_o;
  coord_t pos_z_o;

  // Mirror of the block: control point table and point count register.
  point_t point_store[MaxPoints];
  logic [CntW-1:0] count_setting;

  // Positions still owed by the block, oldest first.
  expected_pos_t pending_points[$];

  int errors;
  int cycles;
  int evals_sent;
  int loads_sent;
  int results_seen;
  int settings_used;
  bit gapless;

  catmull_rom_spline_point #(
    .MaxPoints(MaxPoints)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .point_index_i(point_index_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .t_value_i    (t_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Guard against a hung block: stop the run at a generous cycle budget.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d positions still pending", cycles,
               pending_points.size());
      $display("catmull_rom_spline_point test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PrintCap) begin
      $display("MISMATCH cycle %0d: %s", cycles, msg);
    end
  endtask

  // Points in use, with the register clamped to 4..MaxPoints, minus one.
  function automatic int segments_in_use();
    int n;
    n = int'(count_setting);
    if (n < int'(MinPoints)) n = int'(MinPoints);
    if (n > MaxPoints) n = MaxPoints;
    return n - 1;
  endfunction

  // One axis of the cubic: exact Q.32 sum, halve with round half up, saturate.
  function automatic coord_t blend_axis(input longint p0, input longint p1, input longint p2,
                                        input longint p3, input longint f, input longint f2,
                                        input longint f3);
    longint e3, e2, e1, e0, acc, q;
    e3 = -p0 + 3 * p1 - 3 * p2 + p3;
    e2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    e1 = p2 - p0;
    e0 = 2 * p1;
    acc = e3 * f3 + e2 * f2 + e1 * f + e0 * FracOne;
    // Arithmetic shift of a signed value floors, as the rounding needs.
    q = (acc + FracOne) >>> OutShift;
    if (q > CoordMax) q = CoordMax;
    if (q < CoordMin) q = CoordMin;
    return coord_t'(q);
  endfunction

  // Position the block must return for parameter t with the current table.
  function automatic point_t spline_point(input logic [TW-1:0] t);
    int last, seg, i0, i1, i2, i3;
    longint scaled, f, f2, f3;
    point_t r;
    last = segments_in_use();
    scaled = longint'(t) * last;
    seg = int'(scaled >> FracW);
    if (seg > last) seg = last;
    f = scaled & (FracOne - 1);
    f2 = (f * f + FracHalf) >> FracW;
    f3 = (f2 * f + FracHalf) >> FracW;
    i1 = seg;
    i0 = (seg == 0) ? 0 : seg - 1;
    i2 = seg + 1;
    i3 = seg + 2;
    // Clamp the neighbors at the end of the curve.
    if (i2 > last) begin
      i2 = i1;
      i3 = i1;
    end
    if (i3 > last) i3 = i2;
    for (int a = 0; a < NumAxes; a++) begin
      r[a] = blend_axis($signed(point_store[i0][a]), $signed(point_store[i1][a]),
                        $signed(point_store[i2][a]), $signed(point_store[i3][a]),
                        f, f2, f3);
    end
    return r;
  endfunction

  // Compare every strobed result with the oldest pending position.
  always @(posedge clk_i) begin : check_results
    point_t seen;
    expected_pos_t want;
    string axis_names[NumAxes];
    axis_names = '{"x", "y", "z"};
    if (rst_ni && done_o) begin
      seen[AxisX] = pos_x_o;
      seen[AxisY] = pos_y_o;
      seen[AxisZ] = pos_z_o;
      results_seen++;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("result with no evaluate pending: x=%h y=%h z=%h",
                                  pos_x_o, pos_y_o, pos_z_o));
      end else begin
        want = pending_points.pop_front();
        for (int a = 0; a < NumAxes; a++) begin
          if (seen[a] !== want.pos[a]) begin
            report_mismatch($sformatf("evaluate #%0d t=%0d pos_%s: got %h, want %h",
                                      want.serial, want.t, axis_names[a], seen[a],
                                      want.pos[a]));
          end
        end
      end
    end
  end

  // Drive one item, hold it until accepted, then advance the mirror.
  task automatic send_item(input logic act, input logic [SlotW-1:0] slot, input coord_t x,
                           input coord_t y, input coord_t z, input logic [TW-1:0] t);
    expected_pos_t owed;
    // Idle at random, with a 22 in 100 chance at each check, unless the burst test is running.
    while (!gapless && $urandom_range(99) < 22) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    point_index_i <= slot;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    t_value_i <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (act == ActLoad) begin
      point_store[slot][AxisX] = x;
      point_store[slot][AxisY] = y;
      point_store[slot][AxisZ] = z;
      loads_sent++;
    end else begin
      owed = '{pos: spline_point(t), t: t, serial: evals_sent};
      pending_points.insert(pending_points.size(), owed);
      evals_sent++;
    end
  endtask

  function automatic coord_t random_coord();
    case ($urandom_range(9)) inside
      [0:4]:   return coord_t'(int'($urandom_range(0, 8388608)) - 4194304);
      [5:7]:   return coord_t'($urandom);
      8:       return coord_t'(CoordMax);
      default: return coord_t'(CoordMin);
    endcase
  endfunction

  // Mostly inside 0..1, some beyond it, some right on a segment boundary.
  function automatic logic [TW-1:0] random_t();
    int segs, k, edge_t;
    segs = segments_in_use();
    k = $urandom_range(0, segs);
    edge_t = (k * 65536 + segs - 1) / segs;
    case ($urandom_range(19)) inside
      [14:16]: return TW'($urandom_range(65536, 131071));
      17:      return TW'(edge_t);
      18:      return TW'((edge_t > 0) ? edge_t - 1 : 0);
      19: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return TOne - 1;
          2:       return TOne;
          default: return TTop;
        endcase
      end
      default: return TW'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic load_point(input logic [SlotW-1:0] slot, input coord_t x, input coord_t y,
                            input coord_t z);
    // Toggle the parameter field too, the block should ignore it on a load.
    send_item(ActLoad, slot, x, y, z, TW'($urandom_range(0, 131071)));
  endtask

  task automatic evaluate_at(input logic [TW-1:0] t);
    send_item(ActEval, SlotW'($urandom_range(0, 15)), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), t);
  endtask

  // Stop issuing, let every result come back and any trailing load settle.
  task automatic drain_pipeline();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic write_point_count(input logic [CntW-1:0] value);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    count_setting = value;
    settings_used++;
  endtask

  // Fill every slot, then probe the reset point count at its corners.
  task automatic test_directed();
    for (int k = 0; k < MaxPoints; k++) begin
      case (k)
        6:       load_point(SlotW'(k), coord_t'(CoordMax), coord_t'(CoordMax),
                            coord_t'(CoordMax));
        7:       load_point(SlotW'(k), coord_t'(CoordMin), coord_t'(CoordMin),
                            coord_t'(CoordMin));
        8:       load_point(SlotW'(k), '0, '0, '0);
        default: load_point(SlotW'(k), coord_t'(k * 196608 - 1310720),
                            coord_t'((k % 3) * 100000 - k * 7001),
                            coord_t'(-k * 123457 + 54321));
      endcase
    end
    evaluate_at('0);              // first segment, p0 clamped to p1
    evaluate_at(TW'(1));
    evaluate_at(TW'(13107));      // just short of the second segment
    evaluate_at(TW'(13108));      // just into it
    evaluate_at(TW'(32768));
    evaluate_at(TW'(58000));      // last segment, p3 clamped to p2
    evaluate_at(TOne - 1);
    evaluate_at(TOne);            // lands on the last point
    evaluate_at(TTop);            // extrapolates past the end
  endtask

  // Walk the register through its corners, in range and out of range.
  task automatic test_point_counts();
    logic [CntW-1:0] counts[7];
    counts = '{MinPoints, CntW'(16), CntW'(0), CntW'(31), CntW'(3), CntW'(17), CntW'(9)};
    foreach (counts[i]) begin
      write_point_count(counts[i]);
      evaluate_at('0);
      evaluate_at(TW'(1));
      evaluate_at(TOne);
      evaluate_at(TTop);
      evaluate_at(random_t());
      evaluate_at(random_t());
    end
  endtask

  // Random loads and evaluates under a fresh point count in each phase.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      if ($urandom_range(3) == 0) write_point_count(CntW'($urandom_range(0, 31)));
      else write_point_count(CntW'($urandom_range(4, 16)));
      repeat (128) begin
        if ($urandom_range(99) < 30) begin
          load_point(SlotW'($urandom_range(0, 15)), random_coord(), random_coord(),
                     random_coord());
        end else begin
          evaluate_at(random_t());
        end
      end
    end
  endtask

  // Full rate: one item every cycle with no gaps, loads mixed between evaluates.
  task automatic test_back_to_back();
    write_point_count(CntW'(16));
    gapless = 1'b1;
    repeat (220) begin
      if ($urandom_range(99) < 25) begin
        load_point(SlotW'($urandom_range(0, 15)), random_coord(), random_coord(),
                   random_coord());
      end else begin
        evaluate_at(random_t());
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    // Drive every input to a known value and hold reset, then release it.
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    action_i <= ActLoad;
    point_index_i <= '0;
    coord_x_i <= '0;
    coord_y_i <= '0;
    coord_z_i <= '0;
    t_value_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    count_setting = PointCountReset;
    errors = 0;
    cycles = 0;
    evals_sent = 0;
    loads_sent = 0;
    results_seen = 0;
    settings_used = 0;
    gapless = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_point_counts();
    test_random_traffic();
    test_back_to_back();
    drain_pipeline();

    $display("covered %0d evaluates (%0d results checked) and %0d loads", evals_sent,
             results_seen, loads_sent);
    $display("across %0d point count writes, in and out of range, gapped and at full rate",
             settings_used);
    if (errors == 0) begin
      $display("catmull_rom_spline_point test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("catmull_rom_spline_point test failed");
    end
    $finish;
  end

endmodule
